[hdl/dhlt_pkg.sv]
`default_nettype none

package dhlt_pkg;

    localparam int ANG_W   = 29;
    localparam int XY_W    = 33;
    localparam int TRIG_W  = 16;
    localparam int LEN_W   = 24;
    localparam int TAB_LEN = 24;

    localparam logic signed [ANG_W-1:0] ANG_PI      = 29'sd52707179;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 29'sd26353589;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 29'sd105414357;
    localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 33'sd652032874;

    localparam logic signed [TRIG_W+1:0] TRIG_MAX = 18'sd16384;
    localparam logic signed [TRIG_W+1:0] TRIG_MIN = -18'sd16384;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_joint;
        logic signed [TRIG_W-1:0] sin_joint;
        logic signed [TRIG_W-1:0] cos_twist;
        logic signed [TRIG_W-1:0] sin_twist;
    } trig_t;

    typedef struct packed {
        logic signed [LEN_W-1:0] length;
        logic signed [LEN_W-1:0] offset;
    } link_t;

    // atan(2^-i) at Q.24
    function automatic logic signed [ANG_W-1:0] atan_entry(input int unsigned idx);
        logic signed [ANG_W-1:0] v;
        unique case (idx)
            0:  v = 29'sd13176795;
            1:  v = 29'sd7778716;
            2:  v = 29'sd4110060;
            3:  v = 29'sd2086331;
            4:  v = 29'sd1047214;
            5:  v = 29'sd524117;
            6:  v = 29'sd262123;
            7:  v = 29'sd131069;
            8:  v = 29'sd65536;
            9:  v = 29'sd32768;
            10: v = 29'sd16384;
            11: v = 29'sd8192;
            12: v = 29'sd4096;
            13: v = 29'sd2048;
            14: v = 29'sd1024;
            15: v = 29'sd512;
            16: v = 29'sd256;
            17: v = 29'sd128;
            18: v = 29'sd64;
            19: v = 29'sd32;
            20: v = 29'sd16;
            21: v = 29'sd8;
            22: v = 29'sd4;
            23: v = 29'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    // q.30 to q1.14, round half up, optional negate, clamp
    function automatic logic signed [TRIG_W-1:0] trig_round(
        input logic signed [XY_W-1:0] v,
        input logic                   neg
    );
        logic signed [XY_W-1:0]     sum;
        logic signed [TRIG_W+1:0]   r;
        logic signed [TRIG_W+1:0]   c;
        sum = v + XY_W'(32768);
        r   = {sum[XY_W-1], sum[XY_W-1:16]};
        if (neg)
            r = -r;
        if (r > TRIG_MAX)
            c = TRIG_MAX;
        else if (r < TRIG_MIN)
            c = TRIG_MIN;
        else
            c = r;
        return c[TRIG_W-1:0];
    endfunction

    // trig product, round half up, clamp to trig range
    function automatic logic signed [TRIG_W-1:0] trig_scale(
        input logic signed [2*TRIG_W-1:0] p
    );
        logic signed [2*TRIG_W:0]     sum;
        logic signed [2*TRIG_W-14:0]  r;
        logic signed [TRIG_W-1:0]     c;
        sum = {p[2*TRIG_W-1], p} + (2*TRIG_W+1)'(8192);
        r   = sum[2*TRIG_W:14];
        if (r > (2*TRIG_W-13)'(16384))
            c = TRIG_W'(16384);
        else if (r < -(2*TRIG_W-13)'(16384))
            c = -TRIG_W'(16384);
        else
            c = r[TRIG_W-1:0];
        return c;
    endfunction

    // length product, round half up, saturate to q8.16
    function automatic logic signed [LEN_W-1:0] len_scale(
        input logic signed [TRIG_W+LEN_W-1:0] p
    );
        logic signed [TRIG_W+LEN_W:0]     sum;
        logic signed [TRIG_W+LEN_W-14:0]  r;
        logic signed [LEN_W-1:0]          c;
        sum = {p[TRIG_W+LEN_W-1], p} + (TRIG_W+LEN_W+1)'(8192);
        r   = sum[TRIG_W+LEN_W:14];
        if (r > (TRIG_W+LEN_W-13)'(8388607))
            c = {1'b0, {(LEN_W-1){1'b1}}};
        else if (r < -(TRIG_W+LEN_W-13)'(8388608))
            c = {1'b1, {(LEN_W-1){1'b0}}};
        else
            c = r[LEN_W-1:0];
        return c;
    endfunction

endpackage

`default_nettype wire

[hdl/dhlt_cordic.sv]
`default_nettype none

module dhlt_cordic #(
    parameter int STAGES = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire logic signed [dhlt_pkg::TRIG_W-1:0]  in_joint,
    input  wire logic signed [dhlt_pkg::TRIG_W-1:0]  in_twist,
    input  wire dhlt_pkg::link_t                     in_link,
    output logic                                     out_valid,
    output dhlt_pkg::trig_t                          out_trig,
    output dhlt_pkg::link_t                          out_link
);

    localparam int AW = dhlt_pkg::ANG_W;
    localparam int XW = dhlt_pkg::XY_W;

    // lane 0 joint angle, lane 1 twist angle
    logic signed [AW-1:0]   z_raw [2];
    logic signed [AW-1:0]   z_wrap [2];
    logic signed [AW-1:0]   z_half [2];
    logic                   neg_half [2];

    logic                   wrap_valid_reg;
    logic signed [AW-1:0]   wrap_z_reg [2];
    dhlt_pkg::link_t        wrap_link_reg;

    logic                   valid_reg [STAGES+1];
    logic                   neg_reg [STAGES+1][2];
    dhlt_pkg::link_t        link_reg [STAGES+1];
    logic signed [AW-1:0]   z_reg [STAGES][2];
    logic signed [XW-1:0]   x_reg [STAGES][2];
    logic signed [XW-1:0]   y_reg [STAGES][2];

    logic                   out_valid_reg;
    dhlt_pkg::trig_t        out_trig_reg;
    dhlt_pkg::link_t        out_link_reg;

    assign z_raw[0] = {{(AW-27){in_joint[15]}}, in_joint, 11'b0};
    assign z_raw[1] = {{(AW-27){in_twist[15]}}, in_twist, 11'b0};

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            if (z_raw[l] > dhlt_pkg::ANG_PI)
                z_wrap[l] = z_raw[l] - dhlt_pkg::ANG_TWO_PI;
            else if (z_raw[l] < -dhlt_pkg::ANG_PI)
                z_wrap[l] = z_raw[l] + dhlt_pkg::ANG_TWO_PI;
            else
                z_wrap[l] = z_raw[l];

            if (wrap_z_reg[l] > dhlt_pkg::ANG_HALF_PI)
            begin
                z_half[l]   = wrap_z_reg[l] - dhlt_pkg::ANG_PI;
                neg_half[l] = 1'b1;
            end
            else if (wrap_z_reg[l] < -dhlt_pkg::ANG_HALF_PI)
            begin
                z_half[l]   = wrap_z_reg[l] + dhlt_pkg::ANG_PI;
                neg_half[l] = 1'b1;
            end
            else
            begin
                z_half[l]   = wrap_z_reg[l];
                neg_half[l] = 1'b0;
            end
        end
    end

    // angle wrap and quadrant fold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_valid_reg <= 1'b0;
            valid_reg[0]   <= 1'b0;
        end
        else
        begin
            wrap_valid_reg <= in_valid;
            valid_reg[0]   <= wrap_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            wrap_z_reg[l] <= z_wrap[l];
            z_reg[0][l]   <= z_half[l];
            neg_reg[0][l] <= neg_half[l];
        end
        wrap_link_reg <= in_link;
        link_reg[0]   <= wrap_link_reg;
    end

    // one micro-rotation per stage
    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic signed [XW-1:0] xs [2];
        logic signed [XW-1:0] ys [2];

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            if (s == 0)
            begin : g_first
                assign xs[l] = dhlt_pkg::CORDIC_GAIN;
                assign ys[l] = '0;
            end
            else
            begin : g_next
                assign xs[l] = x_reg[s-1][l];
                assign ys[l] = y_reg[s-1][l];
            end

            always_ff @(posedge clk)
            begin
                if (!z_reg[s][l][AW-1])
                begin
                    x_reg[s][l] <= xs[l] - (ys[l] >>> s);
                    y_reg[s][l] <= ys[l] + (xs[l] >>> s);
                end
                else
                begin
                    x_reg[s][l] <= xs[l] + (ys[l] >>> s);
                    y_reg[s][l] <= ys[l] - (xs[l] >>> s);
                end
                neg_reg[s+1][l] <= neg_reg[s][l];
            end

            if (s < STAGES - 1)
            begin : g_resid
                always_ff @(posedge clk)
                begin
                    if (!z_reg[s][l][AW-1])
                        z_reg[s+1][l] <= z_reg[s][l] - dhlt_pkg::atan_entry(s);
                    else
                        z_reg[s+1][l] <= z_reg[s][l] + dhlt_pkg::atan_entry(s);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s+1] <= 1'b0;
            else
                valid_reg[s+1] <= valid_reg[s];
        end

        always_ff @(posedge clk)
        begin
            link_reg[s+1] <= link_reg[s];
        end
    end

    // rounding to q1.14
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= valid_reg[STAGES];
    end

    always_ff @(posedge clk)
    begin
        out_trig_reg.cos_joint <= dhlt_pkg::trig_round(x_reg[STAGES-1][0], neg_reg[STAGES][0]);
        out_trig_reg.sin_joint <= dhlt_pkg::trig_round(y_reg[STAGES-1][0], neg_reg[STAGES][0]);
        out_trig_reg.cos_twist <= dhlt_pkg::trig_round(x_reg[STAGES-1][1], neg_reg[STAGES][1]);
        out_trig_reg.sin_twist <= dhlt_pkg::trig_round(y_reg[STAGES-1][1], neg_reg[STAGES][1]);
        out_link_reg           <= link_reg[STAGES];
    end

    assign out_valid = out_valid_reg;
    assign out_trig  = out_trig_reg;
    assign out_link  = out_link_reg;

endmodule

`default_nettype wire

[hdl/dhlt_product.sv]
`default_nettype none

module dhlt_product (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire dhlt_pkg::trig_t                     in_trig,
    input  wire dhlt_pkg::link_t                     in_link,
    output logic                                     done,
    output logic signed [dhlt_pkg::TRIG_W-1:0]       m00_cos_joint,
    output logic signed [dhlt_pkg::TRIG_W-1:0]       m01_neg_sin_joint,
    output logic signed [dhlt_pkg::LEN_W-1:0]        m03_x_shift,
    output logic signed [dhlt_pkg::TRIG_W-1:0]       m10_term,
    output logic signed [dhlt_pkg::TRIG_W-1:0]       m11_term,
    output logic signed [dhlt_pkg::TRIG_W-1:0]       m12_neg_sin_twist,
    output logic signed [dhlt_pkg::LEN_W-1:0]        m13_y_shift,
    output logic signed [dhlt_pkg::TRIG_W-1:0]       m20_term,
    output logic signed [dhlt_pkg::TRIG_W-1:0]       m21_term,
    output logic signed [dhlt_pkg::TRIG_W-1:0]       m22_cos_twist,
    output logic signed [dhlt_pkg::LEN_W-1:0]        m23_z_shift
);

    localparam int TW = dhlt_pkg::TRIG_W;
    localparam int LW = dhlt_pkg::LEN_W;

    logic signed [TW-1:0]       neg_sin_twist;

    logic                       mul_valid_reg;
    dhlt_pkg::trig_t            mul_trig_reg;
    logic signed [LW-1:0]       mul_length_reg;
    logic signed [2*TW-1:0]     p10_reg;
    logic signed [2*TW-1:0]     p11_reg;
    logic signed [2*TW-1:0]     p20_reg;
    logic signed [2*TW-1:0]     p21_reg;
    logic signed [TW+LW-1:0]    p13_reg;
    logic signed [TW+LW-1:0]    p23_reg;

    logic                       done_reg;
    logic signed [TW-1:0]       m00_reg;
    logic signed [TW-1:0]       m01_reg;
    logic signed [LW-1:0]       m03_reg;
    logic signed [TW-1:0]       m10_reg;
    logic signed [TW-1:0]       m11_reg;
    logic signed [TW-1:0]       m12_reg;
    logic signed [LW-1:0]       m13_reg;
    logic signed [TW-1:0]       m20_reg;
    logic signed [TW-1:0]       m21_reg;
    logic signed [TW-1:0]       m22_reg;
    logic signed [LW-1:0]       m23_reg;

    assign neg_sin_twist = -in_trig.sin_twist;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= in_valid;
            done_reg      <= mul_valid_reg;
        end
    end

    // products
    always_ff @(posedge clk)
    begin
        mul_trig_reg   <= in_trig;
        mul_length_reg <= in_link.length;
        p10_reg        <= in_trig.sin_joint * in_trig.cos_twist;
        p11_reg        <= in_trig.cos_joint * in_trig.cos_twist;
        p20_reg        <= in_trig.sin_joint * in_trig.sin_twist;
        p21_reg        <= in_trig.cos_joint * in_trig.sin_twist;
        p13_reg        <= neg_sin_twist * in_link.offset;
        p23_reg        <= in_trig.cos_twist * in_link.offset;
    end

    // rounding and saturation
    always_ff @(posedge clk)
    begin
        m00_reg <= mul_trig_reg.cos_joint;
        m01_reg <= -mul_trig_reg.sin_joint;
        m03_reg <= mul_length_reg;
        m10_reg <= dhlt_pkg::trig_scale(p10_reg);
        m11_reg <= dhlt_pkg::trig_scale(p11_reg);
        m12_reg <= -mul_trig_reg.sin_twist;
        m13_reg <= dhlt_pkg::len_scale(p13_reg);
        m20_reg <= dhlt_pkg::trig_scale(p20_reg);
        m21_reg <= dhlt_pkg::trig_scale(p21_reg);
        m22_reg <= mul_trig_reg.cos_twist;
        m23_reg <= dhlt_pkg::len_scale(p23_reg);
    end

    assign done              = done_reg;
    assign m00_cos_joint     = m00_reg;
    assign m01_neg_sin_joint = m01_reg;
    assign m03_x_shift       = m03_reg;
    assign m10_term          = m10_reg;
    assign m11_term          = m11_reg;
    assign m12_neg_sin_twist = m12_reg;
    assign m13_y_shift       = m13_reg;
    assign m20_term          = m20_reg;
    assign m21_term          = m21_reg;
    assign m22_cos_twist     = m22_reg;
    assign m23_z_shift       = m23_reg;

endmodule

`default_nettype wire

[hdl/dh_link_transform.sv]
// channel   | ports                                              | transfer when
// ----------+----------------------------------------------------+---------------------
// request   | start, busy, twist_angle, link_length,             | start high, busy low
//           | link_offset, joint_angle                           |
// result    | done, m00_cos_joint .. m23_z_shift (eleven fields) | done high
//
// one link per cycle in, one result per cycle out; a link passes through the
// two-register angle wrap and fold, one cordic rotation per stage, rounding,
// the multiplier stage and the saturation stage
// busy is held low: the pipeline never stalls and the receiver cannot stall
// rst_n clears only the valid bits, so no result appears until a request is taken
`default_nettype none

module dh_link_transform #(
    parameter int TRIG_STAGES = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [dhlt_pkg::TRIG_W-1:0]  twist_angle,
    input  wire logic signed [dhlt_pkg::LEN_W-1:0]   link_length,
    input  wire logic signed [dhlt_pkg::LEN_W-1:0]   link_offset,
    input  wire logic signed [dhlt_pkg::TRIG_W-1:0]  joint_angle,
    output logic                                     done,
    output logic signed [dhlt_pkg::TRIG_W-1:0]       m00_cos_joint,
    output logic signed [dhlt_pkg::TRIG_W-1:0]       m01_neg_sin_joint,
    output logic signed [dhlt_pkg::LEN_W-1:0]        m03_x_shift,
    output logic signed [dhlt_pkg::TRIG_W-1:0]       m10_term,
    output logic signed [dhlt_pkg::TRIG_W-1:0]       m11_term,
    output logic signed [dhlt_pkg::TRIG_W-1:0]       m12_neg_sin_twist,
    output logic signed [dhlt_pkg::LEN_W-1:0]        m13_y_shift,
    output logic signed [dhlt_pkg::TRIG_W-1:0]       m20_term,
    output logic signed [dhlt_pkg::TRIG_W-1:0]       m21_term,
    output logic signed [dhlt_pkg::TRIG_W-1:0]       m22_cos_twist,
    output logic signed [dhlt_pkg::LEN_W-1:0]        m23_z_shift
);

    localparam int STAGES = (TRIG_STAGES > dhlt_pkg::TAB_LEN) ? dhlt_pkg::TAB_LEN
                                                               : TRIG_STAGES;

    logic               accept;
    dhlt_pkg::link_t    in_link;
    logic               trig_valid;
    dhlt_pkg::trig_t    trig;
    dhlt_pkg::link_t    trig_link;

    assign busy           = 1'b0;
    assign accept         = start & ~busy;
    assign in_link.length = link_length;
    assign in_link.offset = link_offset;

    dhlt_cordic #(
        .STAGES (STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_joint  (joint_angle),
        .in_twist  (twist_angle),
        .in_link   (in_link),
        .out_valid (trig_valid),
        .out_trig  (trig),
        .out_link  (trig_link)
    );

    dhlt_product u_product (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (trig_valid),
        .in_trig           (trig),
        .in_link           (trig_link),
        .done              (done),
        .m00_cos_joint     (m00_cos_joint),
        .m01_neg_sin_joint (m01_neg_sin_joint),
        .m03_x_shift       (m03_x_shift),
        .m10_term          (m10_term),
        .m11_term          (m11_term),
        .m12_neg_sin_twist (m12_neg_sin_twist),
        .m13_y_shift       (m13_y_shift),
        .m20_term          (m20_term),
        .m21_term          (m21_term),
        .m22_cos_twist     (m22_cos_twist),
        .m23_z_shift       (m23_z_shift)
    );

endmodule

`default_nettype wire

[bench/dh_link_checker.sv]
module dh_link_checker #(
    parameter int TRIG_STAGES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic signed [dhlt_pkg::TRIG_W-1:0] twist_angle,
    input  logic signed [dhlt_pkg::LEN_W-1:0]  link_length,
    input  logic signed [dhlt_pkg::LEN_W-1:0]  link_offset,
    input  logic signed [dhlt_pkg::TRIG_W-1:0] joint_angle,
    input  logic                               done,
    input  logic signed [dhlt_pkg::TRIG_W-1:0] m00_cos_joint,
    input  logic signed [dhlt_pkg::TRIG_W-1:0] m01_neg_sin_joint,
    input  logic signed [dhlt_pkg::LEN_W-1:0]  m03_x_shift,
    input  logic signed [dhlt_pkg::TRIG_W-1:0] m10_term,
    input  logic signed [dhlt_pkg::TRIG_W-1:0] m11_term,
    input  logic signed [dhlt_pkg::TRIG_W-1:0] m12_neg_sin_twist,
    input  logic signed [dhlt_pkg::LEN_W-1:0]  m13_y_shift,
    input  logic signed [dhlt_pkg::TRIG_W-1:0] m20_term,
    input  logic signed [dhlt_pkg::TRIG_W-1:0] m21_term,
    input  logic signed [dhlt_pkg::TRIG_W-1:0] m22_cos_twist,
    input  logic signed [dhlt_pkg::LEN_W-1:0]  m23_z_shift,
    output int                                 mismatches,
    output int                                 outstanding
);

    localparam int TW = dhlt_pkg::TRIG_W;
    localparam int LW = dhlt_pkg::LEN_W;

    localparam longint PI_Q24      = 52707179;
    localparam longint HALF_PI_Q24 = 26353589;
    localparam longint TWO_PI_Q24  = 105414357;
    localparam longint START_GAIN  = 652032874;
    localparam longint UNIT_Q14    = 16384;
    localparam longint LEN_HI      = 8388607;
    localparam longint LEN_LO      = -8388608;

    localparam longint ATAN_Q24 [24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    typedef struct packed {
        logic signed [TW-1:0] m00;
        logic signed [TW-1:0] m01;
        logic signed [LW-1:0] m03;
        logic signed [TW-1:0] m10;
        logic signed [TW-1:0] m11;
        logic signed [TW-1:0] m12;
        logic signed [LW-1:0] m13;
        logic signed [TW-1:0] m20;
        logic signed [TW-1:0] m21;
        logic signed [TW-1:0] m22;
        logic signed [LW-1:0] m23;
    } link_tf_t;

    link_tf_t expected_links [$];
    int       fails = 0;
    int       backlog = 0;

    assign mismatches  = fails;
    assign outstanding = backlog;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint round_q14(input longint p);
        return (p + 8192) >>> 14;
    endfunction

    function automatic void sin_cos(input logic signed [TW-1:0] ang,
                                    output longint s, output longint c);
        longint z;
        longint x;
        longint y;
        longint t;
        bit     flip;
        int     n;
        z    = longint'(ang) * 2048;
        x    = START_GAIN;
        y    = 0;
        t    = 0;
        flip = 1'b0;
        n    = (TRIG_STAGES > 24) ? 24 : TRIG_STAGES;
        if (z > PI_Q24)
            z = z - TWO_PI_Q24;
        if (z < -PI_Q24)
            z = z + TWO_PI_Q24;
        if (z > HALF_PI_Q24)
        begin
            z    = z - PI_Q24;
            flip = 1'b1;
        end
        else if (z < -HALF_PI_Q24)
        begin
            z    = z + PI_Q24;
            flip = 1'b1;
        end
        for (int i = 0; i < n; i++)
        begin
            if (z >= 0)
            begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ATAN_Q24[i];
            end
            else
            begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ATAN_Q24[i];
            end
            x = t;
        end
        x = (x + 32768) >>> 16;
        y = (y + 32768) >>> 16;
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = clip(x, -UNIT_Q14, UNIT_Q14);
        s = clip(y, -UNIT_Q14, UNIT_Q14);
    endfunction

    function automatic link_tf_t link_matrix(input logic signed [TW-1:0] alpha,
                                             input logic signed [LW-1:0] a,
                                             input logic signed [LW-1:0] d,
                                             input logic signed [TW-1:0] theta);
        link_tf_t m;
        longint   sa;
        longint   ca;
        longint   st;
        longint   ct;
        longint   dl;
        sin_cos(alpha, sa, ca);
        sin_cos(theta, st, ct);
        dl    = longint'(d);
        m.m00 = TW'(ct);
        m.m01 = TW'(-st);
        m.m03 = a;
        m.m10 = TW'(clip(round_q14(st * ca), -UNIT_Q14, UNIT_Q14));
        m.m11 = TW'(clip(round_q14(ct * ca), -UNIT_Q14, UNIT_Q14));
        m.m12 = TW'(-sa);
        m.m13 = LW'(clip(round_q14(-sa * dl), LEN_LO, LEN_HI));
        m.m20 = TW'(clip(round_q14(st * sa), -UNIT_Q14, UNIT_Q14));
        m.m21 = TW'(clip(round_q14(ct * sa), -UNIT_Q14, UNIT_Q14));
        m.m22 = TW'(ca);
        m.m23 = LW'(clip(round_q14(ca * dl), LEN_LO, LEN_HI));
        return m;
    endfunction

    task automatic check_field(input string name, input logic signed [LW-1:0] want,
                               input logic signed [LW-1:0] got);
        if (got !== want)
        begin
            fails++;
            $display("%0t %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        link_tf_t want;
        if (rst_n === 1'b1)
        begin
            if (start === 1'b1 && busy === 1'b0)
                expected_links.push_back(link_matrix(twist_angle, link_length,
                                                     link_offset, joint_angle));
            if (done === 1'b1)
            begin
                if (expected_links.size() == 0)
                begin
                    fails++;
                    $display("%0t result expected none got m00 %0d m03 %0d m23 %0d",
                             $time, m00_cos_joint, m03_x_shift, m23_z_shift);
                end
                else
                begin
                    want = expected_links.pop_front();
                    check_field("m00_cos_joint", want.m00, m00_cos_joint);
                    check_field("m01_neg_sin_joint", want.m01, m01_neg_sin_joint);
                    check_field("m03_x_shift", want.m03, m03_x_shift);
                    check_field("m10_term", want.m10, m10_term);
                    check_field("m11_term", want.m11, m11_term);
                    check_field("m12_neg_sin_twist", want.m12, m12_neg_sin_twist);
                    check_field("m13_y_shift", want.m13, m13_y_shift);
                    check_field("m20_term", want.m20, m20_term);
                    check_field("m21_term", want.m21, m21_term);
                    check_field("m22_cos_twist", want.m22, m22_cos_twist);
                    check_field("m23_z_shift", want.m23, m23_z_shift);
                end
            end
            backlog = expected_links.size();
        end
    end

endmodule

[bench/dh_link_transform_test.sv]
module dh_link_transform_test;

    localparam int TW     = dhlt_pkg::TRIG_W;
    localparam int LW     = dhlt_pkg::LEN_W;
    localparam int STAGES = 16;
    localparam int ITEMS  = 600;

    localparam int ANGLE_EDGES [8] = '{25737, -25737, 12868, -12868, 0, 32767, -32768, 25736};

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic signed [TW-1:0] twist_angle;
    logic signed [LW-1:0] link_length;
    logic signed [LW-1:0] link_offset;
    logic signed [TW-1:0] joint_angle;
    logic                 done;
    logic signed [TW-1:0] m00_cos_joint;
    logic signed [TW-1:0] m01_neg_sin_joint;
    logic signed [LW-1:0] m03_x_shift;
    logic signed [TW-1:0] m10_term;
    logic signed [TW-1:0] m11_term;
    logic signed [TW-1:0] m12_neg_sin_twist;
    logic signed [LW-1:0] m13_y_shift;
    logic signed [TW-1:0] m20_term;
    logic signed [TW-1:0] m21_term;
    logic signed [TW-1:0] m22_cos_twist;
    logic signed [LW-1:0] m23_z_shift;

    int mismatches;
    int outstanding;
    int sent = 0;

    dh_link_transform #(
        .TRIG_STAGES(STAGES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .twist_angle(twist_angle),
        .link_length(link_length),
        .link_offset(link_offset),
        .joint_angle(joint_angle),
        .done(done),
        .m00_cos_joint(m00_cos_joint),
        .m01_neg_sin_joint(m01_neg_sin_joint),
        .m03_x_shift(m03_x_shift),
        .m10_term(m10_term),
        .m11_term(m11_term),
        .m12_neg_sin_twist(m12_neg_sin_twist),
        .m13_y_shift(m13_y_shift),
        .m20_term(m20_term),
        .m21_term(m21_term),
        .m22_cos_twist(m22_cos_twist),
        .m23_z_shift(m23_z_shift)
    );

    dh_link_checker #(
        .TRIG_STAGES(STAGES)
    ) matrix_check (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .twist_angle(twist_angle),
        .link_length(link_length),
        .link_offset(link_offset),
        .joint_angle(joint_angle),
        .done(done),
        .m00_cos_joint(m00_cos_joint),
        .m01_neg_sin_joint(m01_neg_sin_joint),
        .m03_x_shift(m03_x_shift),
        .m10_term(m10_term),
        .m11_term(m11_term),
        .m12_neg_sin_twist(m12_neg_sin_twist),
        .m13_y_shift(m13_y_shift),
        .m20_term(m20_term),
        .m21_term(m21_term),
        .m22_cos_twist(m22_cos_twist),
        .m23_z_shift(m23_z_shift),
        .mismatches(mismatches),
        .outstanding(outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [TW-1:0] pick_angle();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return TW'($urandom);
        else if (sel < 8)
            return TW'(ANGLE_EDGES[$urandom_range(0, 7)] + $urandom_range(0, 4) - 2);
        else
            return TW'($urandom_range(0, 2000) - 1000);
    endfunction

    function automatic logic signed [LW-1:0] pick_length();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel < 5)
            return LW'($urandom);
        else if (sel == 5)
            return $urandom_range(0, 1) ? LW'(8388607 - $urandom_range(0, 3))
                                        : LW'(-8388608 + $urandom_range(0, 3));
        else
            return LW'($urandom_range(0, 131072) - 65536);
    endfunction

    task automatic send_link(input logic signed [TW-1:0] alpha,
                             input logic signed [LW-1:0] a,
                             input logic signed [LW-1:0] d,
                             input logic signed [TW-1:0] theta);
        @(negedge clk);
        start       <= 1'b1;
        twist_angle <= alpha;
        link_length <= a;
        link_offset <= d;
        joint_angle <= theta;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sent++;
    endtask

    // junk on the fields while start is low
    task automatic pause(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start       <= 1'b0;
            twist_angle <= TW'($urandom);
            link_length <= LW'($urandom);
            link_offset <= LW'($urandom);
            joint_angle <= TW'($urandom);
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("dh_link_transform: mismatch");
        $finish;
    end

    initial
    begin
        int  burst;
        bit  drained;
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        twist_angle = '0;
        link_length = '0;
        link_offset = '0;
        joint_angle = '0;
        drained     = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        pause(2);

        // field extremes, fold boundaries and length saturation
        send_link(16'sd0, 24'sd0, 24'sd0, 16'sd0);
        send_link(16'sd32767, 24'sd8388607, 24'sd8388607, -16'sd32768);
        send_link(-16'sd32768, -24'sd8388608, -24'sd8388608, 16'sd32767);
        send_link(16'sd25736, 24'sd65536, 24'sd65536, 16'sd25737);
        send_link(16'sd25737, -24'sd65536, 24'sd1, -16'sd25737);
        send_link(-16'sd25736, 24'sd1, -24'sd1, -16'sd25736);
        send_link(-16'sd25737, 24'sd100, 24'sd8388607, 16'sd25736);
        send_link(16'sd12867, 24'sd0, 24'sd8388607, 16'sd12868);
        send_link(16'sd12868, 24'sd0, -24'sd8388608, -16'sd12868);
        send_link(-16'sd12868, 24'sd0, -24'sd8388608, -16'sd12867);
        send_link(-16'sd12867, 24'sd0, 24'sd8388607, 16'sd12867);
        send_link(16'sd25736, 24'sd0, -24'sd8388608, 16'sd0);
        send_link(-16'sd25736, 24'sd0, 24'sd8388607, 16'sd6434);
        send_link(16'sd1, 24'sd8388607, -24'sd8388608, -16'sd1);
        send_link(-16'sd1, -24'sd8388608, 24'sd8388607, 16'sd1);
        send_link(16'sd6434, 24'sd12345, -24'sd54321, -16'sd6434);
        pause(3);

        while (sent < ITEMS + 16)
        begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
            repeat (burst)
                send_link(pick_angle(), pick_length(), pick_length(), pick_angle());
            if (!drained && sent > ITEMS / 2)
            begin
                pause(1);
                wait (outstanding == 0);
                drained = 1'b1;
            end
            pause(($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 5));
        end

        pause(1);
        wait (outstanding == 0);
        repeat (STAGES + 10) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("dh_link_transform: match");
        else
            $display("dh_link_transform: mismatch");
        $finish;
    end

endmodule
